@@ rtl/aes256_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-256 shared package
// S-box tables, GF(2^8) helpers, controller state and command types.
// ----------------------------------------------------------------------------
package aes256_pkg;

    localparam int KEY_WORDS = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] CFG_KEY_0 = 2'd0;
    localparam logic [1:0] CFG_KEY_1 = 2'd1;
    localparam logic [1:0] CFG_KEY_2 = 2'd2;
    localparam logic [1:0] CFG_KEY_3 = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUND,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;       // capture input block and start key expansion
        logic exp_step;   // compute one schedule word
        logic rnd_first;  // initial key addition
        logic rnd_step;   // one cipher round
    } t_cmd;

    typedef struct packed {
        logic exp_done;
        logic rnd_done;
    } t_status;

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] x, input logic [3:0] y);
        logic [7:0] a;
        logic [7:0] acc;
        a   = x;
        acc = 8'h00;
        for (int n = 0; n < 4; n++) begin
            if (y[n]) acc = acc ^ a;
            a = xtime(a);
        end
        return acc;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] v);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[v];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[v];
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

@@ rtl/aes256_ctrl.sv @@
// ----------------------------------------------------------------------------
// AES-256 controller
// Sequences key expansion, the rounds and the result handoff.
// ----------------------------------------------------------------------------
module aes256_ctrl
    import aes256_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_EXPAND;
            ST_EXPAND: if (i_status.exp_done) n_state = ST_ROUND;
            ST_ROUND:  if (i_status.rnd_done) n_state = ST_OUT;
            ST_OUT:    if (!i_out_stall) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_EXPAND: begin
                o_cmd.exp_step  = !i_status.exp_done;
                o_cmd.rnd_first = i_status.exp_done;
            end
            ST_ROUND: o_cmd.rnd_step = 1'b1;
            ST_OUT: begin
                o_out_valid = 1'b1;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

@@ rtl/aes256_dpath.sv @@
// ----------------------------------------------------------------------------
// AES-256 datapath
// Key schedule memory, schedule word generator and one shared round unit.
// ----------------------------------------------------------------------------
module aes256_dpath
    import aes256_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [255:0]  i_key,
    input  logic          i_func,
    input  logic [127:0]  i_block,
    output t_status       o_status,
    output logic [127:0]  o_result
);

    localparam int ROUNDS = KEY_WORDS + 6;
    localparam int SCHED  = 4 * (ROUNDS + 1);
    localparam int WI_W   = $clog2(SCHED + 1);
    localparam int RK_W   = $clog2(ROUNDS + 1);

    // Round keys kept as one 128-bit row per round; schedule words are
    // gathered four at a time into a row before it is written.
    logic [127:0] r_rk_mem [ROUNDS + 1];
    logic [31:0]  r_win [KEY_WORDS];     // sliding window of last KEY_WORDS words
    logic [WI_W-1:0] r_wi;
    logic [7:0]   r_rcon;
    logic [127:0] r_state;
    logic         r_func;
    logic [RK_W-1:0] r_rnd;
    logic [127:0] r_rk_q;
    logic [127:0] r_row;

    // Next schedule word
    logic [31:0] w_t, w_new;
    logic [2:0]  w_mod;
    always_comb begin
        w_mod = r_wi[2:0];
        w_t   = r_win[KEY_WORDS-1];
        if (w_mod == 3'd0)
            w_t = sbox_word({w_t[23:0], w_t[31:24]}) ^ {r_rcon, 24'h0};
        else if (w_mod == 3'd4)
            w_t = sbox_word(w_t);
        w_new = r_win[0] ^ w_t;
    end

    logic w_out_word;
    assign w_out_word = (r_wi >= WI_W'(KEY_WORDS));
    assign o_status.exp_done = (r_wi == WI_W'(SCHED));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < KEY_WORDS; k++)
                r_win[k] <= i_key[255 - 32*k -: 32];
            r_wi   <= '0;
            r_rcon <= 8'h01;
        end else if (i_cmd.exp_step) begin
            // first KEY_WORDS steps just stream the key words into the rows
            if (w_out_word) begin
                for (int k = 0; k < KEY_WORDS - 1; k++) r_win[k] <= r_win[k+1];
                r_win[KEY_WORDS-1] <= w_new;
                if (w_mod == 3'd0) r_rcon <= xtime(r_rcon);
            end
            r_wi <= r_wi + WI_W'(1);
        end
    end

    // Word written this step, packed into 128-bit rows
    logic [31:0] w_wr;
    assign w_wr = w_out_word ? w_new : r_win[r_wi[2:0]];

    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_step) begin
            r_row <= {r_row[95:0], w_wr};
            if (r_wi[1:0] == 2'd3)
                r_rk_mem[r_wi[WI_W-1:2]] <= {r_row[95:0], w_wr};
        end
    end

    // Round key read, registered; fetch the key of the round after the one
    // that is running now
    logic [RK_W-1:0] w_rd_addr;
    logic w_last;
    assign w_last = (r_rnd == RK_W'(ROUNDS - 1));
    always_comb begin
        if (i_cmd.rnd_first) w_rd_addr = r_func ? RK_W'(ROUNDS - 1) : RK_W'(1);
        else if (w_last)     w_rd_addr = '0;
        else                 w_rd_addr = r_func ? RK_W'(ROUNDS - 2) - r_rnd
                                                : r_rnd + RK_W'(2);
    end
    always_ff @(posedge i_clk) r_rk_q <= r_rk_mem[w_rd_addr];

    // Round unit
    logic [7:0] s  [16];
    logic [7:0] ss [16];
    logic [7:0] fm [16];
    logic [7:0] im [16];
    logic [7:0] dm [16];
    logic [127:0] w_next;
    always_comb begin
        for (int k = 0; k < 16; k++) s[k] = r_state[127 - 8*k -: 8];
        for (int k = 0; k < 16; k++) ss[k] = 8'h00;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                if (!r_func) ss[4*c + r] = sbox(s[4*((c + r) % 4) + r]);
                else         ss[4*((c + r) % 4) + r] = inv_sbox(s[4*c + r]);
            end
        for (int c = 0; c < 4; c++) begin
            fm[4*c]   = gmul(ss[4*c],4'h2)^gmul(ss[4*c+1],4'h3)^ss[4*c+2]^ss[4*c+3];
            fm[4*c+1] = ss[4*c]^gmul(ss[4*c+1],4'h2)^gmul(ss[4*c+2],4'h3)^ss[4*c+3];
            fm[4*c+2] = ss[4*c]^ss[4*c+1]^gmul(ss[4*c+2],4'h2)^gmul(ss[4*c+3],4'h3);
            fm[4*c+3] = gmul(ss[4*c],4'h3)^ss[4*c+1]^ss[4*c+2]^gmul(ss[4*c+3],4'h2);
        end
        for (int k = 0; k < 16; k++) im[k] = ss[k] ^ r_rk_q[127 - 8*k -: 8];
        for (int c = 0; c < 4; c++) begin
            dm[4*c]   = gmul(im[4*c],4'he)^gmul(im[4*c+1],4'hb)
                      ^gmul(im[4*c+2],4'hd)^gmul(im[4*c+3],4'h9);
            dm[4*c+1] = gmul(im[4*c],4'h9)^gmul(im[4*c+1],4'he)
                      ^gmul(im[4*c+2],4'hb)^gmul(im[4*c+3],4'hd);
            dm[4*c+2] = gmul(im[4*c],4'hd)^gmul(im[4*c+1],4'h9)
                      ^gmul(im[4*c+2],4'he)^gmul(im[4*c+3],4'hb);
            dm[4*c+3] = gmul(im[4*c],4'hb)^gmul(im[4*c+1],4'hd)
                      ^gmul(im[4*c+2],4'h9)^gmul(im[4*c+3],4'he);
        end
        for (int k = 0; k < 16; k++) begin
            if (!r_func) w_next[127 - 8*k -: 8] =
                (w_last ? im[k] : fm[k] ^ r_rk_q[127 - 8*k -: 8]);
            else w_next[127 - 8*k -: 8] = w_last ? im[k] : dm[k];
        end
    end

    // Encrypt last round: im = ss ^ key already (no mix); decrypt last: no inverse mix
    assign o_status.rnd_done = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd <= '0;
        end else if (i_cmd.load) begin
            r_func  <= i_func;
            r_state <= i_block;
        end else if (i_cmd.rnd_first) begin
            r_state <= r_state ^ r_rk_mem[r_func ? RK_W'(ROUNDS) : RK_W'(0)];
            r_rnd   <= '0;
        end else if (i_cmd.rnd_step) begin
            r_state <= w_next;
            r_rnd   <= w_last ? '0 : r_rnd + RK_W'(1);
        end
    end

    assign o_result = r_state;

endmodule

@@ rtl/aes256_block_cipher_core.sv @@
// ----------------------------------------------------------------------------
// AES-256 block cipher core
// Sequence: from the accepting edge to o_valid the core builds 60 key
// schedule words (one word per cycle), adds the initial key and runs 14
// rounds on one round unit. One transaction at a time: the key schedule is
// rebuilt for every block and the next is accepted once the result is taken.
// Reset: synchronous active low; key registers clear to zero, control idles.
// ----------------------------------------------------------------------------
module aes256_block_cipher_core
    import aes256_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_func,
    input  logic [63:0]          i_block_high,
    input  logic [63:0]          i_block_low,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [63:0]          o_result_high,
    output logic [63:0]          o_result_low
);

    logic [63:0] r_key [4];
    t_cmd        w_cmd;
    t_status     w_status;
    logic [127:0] w_result;

    // Key registers; the datapath samples them when a transaction is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_0: r_key[0] <= i_cfg_data;
                CFG_KEY_1: r_key[1] <= i_cfg_data;
                CFG_KEY_2: r_key[2] <= i_cfg_data;
                CFG_KEY_3: r_key[3] <= i_cfg_data;
                default:   r_key[0] <= r_key[0];
            endcase
        end
    end

    aes256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_stall (i_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    // Expand the key fresh for every transaction so a new key always applies
    aes256_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_key    ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_func   (i_func),
        .i_block  ({i_block_high, i_block_low}),
        .o_status (w_status),
        .o_result (w_result)
    );

    assign o_result_high = w_result[127:64];
    assign o_result_low  = w_result[63:0];

    // Hold the result while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_high)) else $error("result moved");
    // No accept while a result is presented on o_valid
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("accept while busy");

endmodule

@@ tb/aes256_block_cipher_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-256 block cipher checker
// Watches the key write port and both channels, computes the expected block
// for each accepted transaction and compares it with the returned block.
// ----------------------------------------------------------------------------
module aes256_block_cipher_checker
    import aes256_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_valid,
    input  logic                 i_stall_in,
    input  logic                 i_func,
    input  logic [63:0]          i_block_high,
    input  logic [63:0]          i_block_low,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic [63:0]          i_result_high,
    input  logic [63:0]          i_result_low,
    output int                   o_errors,
    output int                   o_pending
);

    localparam int FIFO_DEPTH = 64;

    logic [63:0]  key_reg [4];
    logic [127:0] exp_fifo [FIFO_DEPTH];
    int           wr_cnt = 0;
    int           rd_cnt = 0;

    function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int n = 0; n < 8; n++) begin
            if (b[n]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // Build the S-box from the field inverse and the affine map.
    logic [7:0] fwd_sub [256];
    logic [7:0] inv_sub [256];
    initial begin
        logic [7:0] inv, base, s;
        for (int v = 0; v < 256; v++) begin
            inv  = 8'h01;
            base = v[7:0];
            for (int e = 0; e < 8; e++) begin
                if ((254 >> e) & 1) inv = gf_mult(inv, base);
                base = gf_mult(base, base);
            end
            if (v == 0) inv = 8'h00;
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_sub[v] = s;
            inv_sub[s] = v[7:0];
        end
    end

    function automatic logic [31:0] sub32(input logic [31:0] w);
        return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
    endfunction

    // Byte k of a block sits at bits 127-8k; column-major state.
    function automatic logic [127:0] mix_cols(input logic [127:0] b, input bit inverse);
        logic [7:0] a [4];
        logic [127:0] o;
        logic [7:0] m [4];
        if (inverse) begin
            m[0] = 8'h0e; m[1] = 8'h0b; m[2] = 8'h0d; m[3] = 8'h09;
        end else begin
            m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = b[127 - 8 * (4 * c + r) -: 8];
            for (int r = 0; r < 4; r++)
                o[127 - 8 * (4 * c + r) -: 8] = gf_mult(a[r], m[0]) ^
                    gf_mult(a[(r + 1) % 4], m[1]) ^ gf_mult(a[(r + 2) % 4], m[2]) ^
                    gf_mult(a[(r + 3) % 4], m[3]);
        end
        return o;
    endfunction

    function automatic logic [127:0] cipher_block(input logic func_dec,
                                                  input logic [127:0] blk);
        logic [31:0]  w [60];
        logic [127:0] rk [15];
        logic [127:0] st, t;
        logic [31:0]  tmp;
        logic [7:0]   rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++)
            w[i] = i[0] ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
        for (int i = 8; i < 60; i++) begin
            tmp = w[i - 1];
            if (i % 8 == 0) begin
                tmp = sub32({tmp[23:0], tmp[31:24]}) ^ {rc, 24'h0};
                rc  = gf_mult(rc, 8'h02);
            end else if (i % 8 == 4) begin
                tmp = sub32(tmp);
            end
            w[i] = w[i - 8] ^ tmp;
        end
        for (int r = 0; r < 15; r++) rk[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
        st = blk;
        if (!func_dec) begin
            st ^= rk[0];
            for (int r = 1; r <= 14; r++) begin
                for (int c = 0; c < 4; c++)
                    for (int q = 0; q < 4; q++)
                        t[127 - 8 * (4 * c + q) -: 8] =
                            fwd_sub[st[127 - 8 * (4 * ((c + q) % 4) + q) -: 8]];
                if (r < 14) t = mix_cols(t, 1'b0);
                st = t ^ rk[r];
            end
        end else begin
            st ^= rk[14];
            for (int r = 13; r >= 0; r--) begin
                for (int c = 0; c < 4; c++)
                    for (int q = 0; q < 4; q++)
                        t[127 - 8 * (4 * ((c + q) % 4) + q) -: 8] =
                            inv_sub[st[127 - 8 * (4 * c + q) -: 8]];
                st = t ^ rk[r];
                if (r > 0) st = mix_cols(st, 1'b1);
            end
        end
        return st;
    endfunction

    assign o_pending = wr_cnt - rd_cnt;

    always @(posedge i_clk) begin
        logic [127:0] exp_blk;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            o_errors <= 0;
            wr_cnt   <= 0;
            rd_cnt   <= 0;
        end else begin
            // Key changes take effect at the next transaction.
            if (i_cfg_we) key_reg[i_cfg_idx] <= i_cfg_data;
            if (i_valid && !i_stall_in) begin
                exp_fifo[wr_cnt % FIFO_DEPTH] <=
                    cipher_block(i_func, {i_block_high, i_block_low});
                wr_cnt <= wr_cnt + 1;
            end
            if (i_res_valid && !i_res_stall) begin
                if (wr_cnt == rd_cnt) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected result %h %h",
                                                i_result_high, i_result_low);
                end else begin
                    exp_blk = exp_fifo[rd_cnt % FIFO_DEPTH];
                    rd_cnt <= rd_cnt + 1;
                    if ({i_result_high, i_result_low} !== exp_blk) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("block mismatch: expected %h %h, got %h %h",
                                     exp_blk[127:64], exp_blk[63:0],
                                     i_result_high, i_result_low);
                    end
                end
            end
        end
    end

endmodule

@@ tb/tb_aes256_block_cipher_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-256 block cipher core testbench
// Drives directed and random blocks under several keys with random idling on
// both channels; a checker compares each result with a computed block.
// ----------------------------------------------------------------------------
module tb_aes256_block_cipher_core
    import aes256_pkg::*;
;

    localparam int LATENCY = 80;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_KEY_0;
    logic [63:0]          i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_func = 1'b0;
    logic [63:0]          i_block_high = '0;
    logic [63:0]          i_block_low = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [63:0]          o_result_high;
    logic [63:0]          o_result_low;
    int                   errors;
    int                   pending;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;

    always #5 i_clk = ~i_clk;

    aes256_block_cipher_core dut (.*);

    aes256_block_cipher_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_stall_in(o_stall), .i_func, .i_block_high, .i_block_low,
        .i_res_valid(o_valid), .i_res_stall(i_stall),
        .i_result_high(o_result_high), .i_result_low(o_result_low),
        .o_errors(errors), .o_pending(pending)
    );

    // Receiver stalls at random, at the falling edge.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Send one transaction; hold it until accepted at a rising edge. Return at
    // the next falling edge with valid still high; the next call or drain
    // replaces or drops it there.
    task automatic send_block(input logic func, input logic [63:0] hi, input logic [63:0] lo);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= func;
        i_block_high <= hi;
        i_block_low  <= lo;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Drop valid, then wait until every expected block has come back.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    // Write all four key registers on consecutive cycles.
    task automatic write_keys(input logic [63:0] k0, input logic [63:0] k1,
                              input logic [63:0] k2, input logic [63:0] k3);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_KEY_0;
        i_cfg_data <= k0;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_KEY_1;
        i_cfg_data <= k1;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_KEY_2;
        i_cfg_data <= k2;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_KEY_3;
        i_cfg_data <= k3;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: all-zero key, then the standard test key, then the all-ones key, both directions.
        send_block(1'b0, '0, '0);
        send_block(1'b1, '0, '0);
        send_block(1'b0, '1, '1);
        send_block(1'b1, '1, '1);
        drain();
        write_keys(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                   64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        send_block(1'b0, 64'h8000000000000000, 64'h0000000000000001);
        send_block(1'b1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        drain();
        write_keys('1, '1, '1, '1);
        send_block(1'b0, '0, '1);
        send_block(1'b1, '1, '0);
        drain();

        // Random phases: new key each phase, idling profile changes.
        for (int ph = 0; ph < 15; ph++) begin
            if (ph < 5) begin
                send_idle_pct = 7;
                recv_idle_pct = 76;
            end else if (ph < 10) begin
                send_idle_pct = 76;
                recv_idle_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_keys(rand64(), rand64(), rand64(), rand64());
            for (int n = 0; n < 50; n++)
                send_block($urandom_range(1), rand64(), rand64());
            drain();
        end

        if (errors == 0) begin
            $display("aes256_block_cipher_core: match");
        end else begin
            $display("aes256_block_cipher_core: mismatch");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("aes256_block_cipher_core: mismatch");
        $finish;
    end

endmodule
